// ===== hdl/lspc_pkg.sv =====
package lspc_pkg;

  // Point and frame geometry.
  localparam int COORD_W  = 18;
  localparam int INTEN_W  = 8;
  localparam int IDX_W    = 16;
  localparam int COUNT_W  = 17;
  localparam int BASE_W   = 16;

  // Arithmetic widths of the shared unit.
  localparam int OP_W     = COORD_W + 1;        // magnitude of a coordinate difference
  localparam int PROD_W   = 2 * OP_W;
  localparam int RAD_W    = 2 * COORD_W;        // x^2 + y^2
  localparam int ROOT_W   = COORD_W;            // integer root of the radius square
  localparam int THR_W    = BASE_W + 1;
  localparam int ROOT_STEPS = ROOT_W;
  localparam int STEP_W   = $clog2(ROOT_STEPS + 1);

  // 0.02 as a fraction of 2^16.
  localparam logic [OP_W-1:0] RANGE_SCALE = OP_W'(1311);
  localparam int SCALE_SHIFT = 16;
  localparam int SCALE_KEEP  = 12;

  localparam logic [COUNT_W-1:0] SIZE_CAP = COUNT_W'(65536);

  // Stream packing.
  localparam int S_TDATA_W = 64;
  localparam int M_TDATA_W = 40;
  localparam int M_PAD_W   = M_TDATA_W - IDX_W - COUNT_W;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 17;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_DIST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEN_JUMP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_POINTS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_POINTS = 2'd3;

  typedef logic signed [COORD_W-1:0] coord_t;

  // Request to the neighbour test unit; the operands are held stable until done.
  typedef struct packed {
    logic               start;
    coord_t             cur_x;
    coord_t             cur_y;
    coord_t             cur_z;
    coord_t             prev_x;
    coord_t             prev_y;
    coord_t             prev_z;
    logic [BASE_W-1:0]  base_dist;
  } lspc_req_t;

  typedef struct packed {
    logic done;
    logic near;
  } lspc_res_t;

  function automatic logic [OP_W-1:0] lspc_abs(input logic signed [OP_W-1:0] v);
    lspc_abs = v[OP_W-1] ? OP_W'(-v) : OP_W'(v);
  endfunction

endpackage

// ===== hdl/lspc_near_unit.sv =====
module lspc_near_unit
  import lspc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  lspc_req_t req,
  output lspc_res_t res
);

  typedef enum logic [9:0] {
    U_IDLE  = 10'b0000000001,
    U_SQX   = 10'b0000000010,
    U_SQY   = 10'b0000000100,
    U_SQDX  = 10'b0000001000,
    U_SQDY  = 10'b0000010000,
    U_SQDZ  = 10'b0000100000,
    U_ROOT  = 10'b0001000000,
    U_SCALE = 10'b0010000000,
    U_THR   = 10'b0100000000,
    U_CMP   = 10'b1000000000
  } ustate_t;

  localparam logic [RAD_W-1:0] BIT_INIT = RAD_W'(1) << (2 * (ROOT_W - 1));

  ustate_t state;
  ustate_t state_next;

  logic [STEP_W-1:0] step_cnt;
  logic [RAD_W-1:0]  rad;
  logic [RAD_W-1:0]  root;
  logic [RAD_W-1:0]  root_bit;
  logic [PROD_W-1:0] sep_sq;
  logic [THR_W-1:0]  thr;
  logic [PROD_W-1:0] thr_sq;

  logic [OP_W-1:0]   mul_a;
  logic [OP_W-1:0]   mul_b;
  logic [PROD_W-1:0] prod;
  logic [RAD_W-1:0]  trial;
  logic              fits;

  logic signed [OP_W-1:0] dx;
  logic signed [OP_W-1:0] dy;
  logic signed [OP_W-1:0] dz;

  assign dx = {req.cur_x[COORD_W-1], req.cur_x} - {req.prev_x[COORD_W-1], req.prev_x};
  assign dy = {req.cur_y[COORD_W-1], req.cur_y} - {req.prev_y[COORD_W-1], req.prev_y};
  assign dz = {req.cur_z[COORD_W-1], req.cur_z} - {req.prev_z[COORD_W-1], req.prev_z};

  // Operand selection for the one shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      U_SQX: begin
        mul_a = lspc_abs({req.cur_x[COORD_W-1], req.cur_x});
        mul_b = mul_a;
      end
      U_SQY: begin
        mul_a = lspc_abs({req.cur_y[COORD_W-1], req.cur_y});
        mul_b = mul_a;
      end
      U_SQDX: begin
        mul_a = lspc_abs(dx);
        mul_b = mul_a;
      end
      U_SQDY: begin
        mul_a = lspc_abs(dy);
        mul_b = mul_a;
      end
      U_SQDZ: begin
        mul_a = lspc_abs(dz);
        mul_b = mul_a;
      end
      U_SCALE: begin
        mul_a = {1'b0, root[ROOT_W-1:0]};
        mul_b = RANGE_SCALE;
      end
      U_THR: begin
        mul_a = {{(OP_W - THR_W){1'b0}}, thr};
        mul_b = mul_a;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod  = mul_a * mul_b;
  assign trial = root + root_bit;
  assign fits  = rad >= trial;

  always_comb begin
    state_next = state;
    unique case (state)
      U_IDLE:  if (req.start) state_next = U_SQX;
      U_SQX:   state_next = U_SQY;
      U_SQY:   state_next = U_SQDX;
      U_SQDX:  state_next = U_SQDY;
      U_SQDY:  state_next = U_SQDZ;
      U_SQDZ:  state_next = U_ROOT;
      U_ROOT:  if (step_cnt == STEP_W'(ROOT_STEPS - 1)) state_next = U_SCALE;
      U_SCALE: state_next = U_THR;
      U_THR:   state_next = U_CMP;
      U_CMP:   state_next = U_IDLE;
      default: state_next = U_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= U_IDLE;
      step_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == U_SQDZ) begin
        step_cnt <= '0;
      end else if (state == U_ROOT) begin
        step_cnt <= step_cnt + STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      U_SQX:  rad <= prod[RAD_W-1:0];
      U_SQY:  rad <= rad + prod[RAD_W-1:0];
      U_SQDX: sep_sq <= prod;
      U_SQDY: sep_sq <= sep_sq + prod;
      U_SQDZ: begin
        sep_sq   <= sep_sq + prod;
        root     <= '0;
        root_bit <= BIT_INIT;
      end
      U_ROOT: begin
        // One result bit per cycle of the restoring square root.
        if (fits) begin
          rad  <= rad - trial;
          root <= (root >> 1) + root_bit;
        end else begin
          root <= root >> 1;
        end
        root_bit <= root_bit >> 2;
      end
      U_SCALE: thr <= THR_W'(req.base_dist) +
                      THR_W'(prod[SCALE_SHIFT +: SCALE_KEEP]);
      U_THR:   thr_sq <= prod;
      default: begin
      end
    endcase
  end

  assign res.done = (state == U_CMP);
  assign res.near = sep_sq < thr_sq;

endmodule

// ===== hdl/lidar_scanline_point_clusterer.sv =====
// Scan-line point clusterer. Points enter on the slave stream in firing order and are
// grouped into runs of neighbouring points: a point joins the open cluster when its squared
// distance to the previous point is below (base_distance_mm + 0.02 * range)^2, where range
// is the integer root of x^2 + y^2 of the new point, and its intensity step is within
// intensity_jump_limit. A break reports the closed cluster (first index, size, accepted
// flag on tuser); a point with tlast set also reports the cluster that holds it, with
// tlast set on that report, and the next point starts a new frame at index 0. A point with
// a predecessor is decided after the five squarings, the 18 one-bit steps of the square
// root, the range scaling, the squaring of the threshold and the comparison; a single
// 19 x 19 multiplier serves the five squarings, the range scaling and the squaring of the
// threshold. The first point of a frame is decided in the cycle after its request is
// accepted. The block then returns to idle, where the next request can be taken, so a new
// point is taken only once the previous one is decided. Each report adds a state in which
// the result is moved to the output register once it is free; the register then holds it
// until the downstream side takes it while the next request is already being accepted.
// Configuration writes are always taken and should only be made while the block is idle.
// Cluster sizes saturate at 65536 and point indexes wrap at 65536.
module lidar_scanline_point_clusterer
  import lspc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // Input points.
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [S_TDATA_W-1:0]  s_tdata,   // pos_x, pos_y, pos_z, intensity, zero pad
  input  logic                  s_tlast,   // frame_end
  // Cluster reports.
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [M_TDATA_W-1:0]  m_tdata,   // first_index, point_count, zero pad
  output logic                  m_tuser,   // accepted
  output logic                  m_tlast,   // frame_done
  // Configuration writes.
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [5:0] {
    T_IDLE  = 6'b000001,
    T_CHECK = 6'b000010,
    T_WAIT  = 6'b000100,
    T_BREAK = 6'b001000,
    T_FRAME = 6'b010000,
    T_SPARE = 6'b100000
  } tstate_t;

  tstate_t state;

  // Configuration.
  logic [BASE_W-1:0]  base_dist;
  logic [INTEN_W-1:0] jump_limit;
  logic [COUNT_W-1:0] min_points;
  logic [COUNT_W-1:0] max_points;

  // Clustering state.
  coord_t             prev_x;
  coord_t             prev_y;
  coord_t             prev_z;
  logic [INTEN_W-1:0] prev_inten;
  logic               have_prev;
  logic [IDX_W-1:0]   point_index;
  logic [IDX_W-1:0]   cluster_start;
  logic [COUNT_W-1:0] cluster_size;

  // Point under work.
  coord_t             cur_x;
  coord_t             cur_y;
  coord_t             cur_z;
  logic [INTEN_W-1:0] cur_inten;
  logic               cur_end;
  logic               inten_ok;

  // Output register.
  logic [IDX_W-1:0]   out_first;
  logic [COUNT_W-1:0] out_count;
  logic               out_acc;
  logic               out_last;

  lspc_req_t          near_req;
  lspc_res_t          near_res;

  logic               in_acc;
  logic               out_free;
  logic               out_load;
  logic               commit;
  logic               join_ok;
  logic [INTEN_W-1:0] inten_step;
  logic               size_ok;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == T_IDLE);
  assign in_acc    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign out_load  = ((state == T_BREAK) || (state == T_FRAME)) && out_free;
  assign join_ok   = near_res.near && inten_ok;

  // A point is folded into the history once its cluster decision has been carried out.
  assign commit = ((state == T_CHECK) && !have_prev) ||
                  ((state == T_WAIT) && near_res.done && join_ok) ||
                  ((state == T_BREAK) && out_free);

  assign inten_step = (cur_inten > prev_inten) ? (cur_inten - prev_inten)
                                               : (prev_inten - cur_inten);
  assign size_ok    = (cluster_size >= min_points) && (cluster_size <= max_points);

  assign near_req.start     = (state == T_CHECK) && have_prev;
  assign near_req.cur_x     = cur_x;
  assign near_req.cur_y     = cur_y;
  assign near_req.cur_z     = cur_z;
  assign near_req.prev_x    = prev_x;
  assign near_req.prev_y    = prev_y;
  assign near_req.prev_z    = prev_z;
  assign near_req.base_dist = base_dist;

  lspc_near_unit u_near (
    .clk (clk),
    .rst (rst),
    .req (near_req),
    .res (near_res)
  );

  // Configuration register file.
  always_ff @(posedge clk) begin
    if (rst) begin
      base_dist  <= BASE_W'(500);
      jump_limit <= INTEN_W'(20);
      min_points <= COUNT_W'(3);
      max_points <= COUNT_W'(1000);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BASE_DIST:  base_dist  <= cfg_data[BASE_W-1:0];
        REG_INTEN_JUMP: jump_limit <= cfg_data[INTEN_W-1:0];
        REG_MIN_POINTS: min_points <= cfg_data[COUNT_W-1:0];
        REG_MAX_POINTS: max_points <= cfg_data[COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer and clustering state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= T_IDLE;
      have_prev     <= 1'b0;
      point_index   <= '0;
      cluster_start <= '0;
      cluster_size  <= '0;
      prev_x        <= '0;
      prev_y        <= '0;
      prev_z        <= '0;
      prev_inten    <= '0;
    end else begin
      unique case (state)
        T_IDLE: begin
          if (in_acc) state <= T_CHECK;
        end
        T_CHECK: begin
          if (have_prev) begin
            state <= T_WAIT;
          end else begin
            cluster_start <= point_index;
            cluster_size  <= COUNT_W'(1);
            state         <= cur_end ? T_FRAME : T_IDLE;
          end
        end
        T_WAIT: begin
          if (near_res.done) begin
            if (join_ok) begin
              if (cluster_size != SIZE_CAP) cluster_size <= cluster_size + COUNT_W'(1);
              state <= cur_end ? T_FRAME : T_IDLE;
            end else begin
              state <= T_BREAK;
            end
          end
        end
        T_BREAK: begin
          // The closed cluster is loaded into the output register once it is free; the new one starts at this point.
          if (out_free) begin
            cluster_start <= point_index;
            cluster_size  <= COUNT_W'(1);
            state         <= cur_end ? T_FRAME : T_IDLE;
          end
        end
        T_FRAME: begin
          if (out_free) state <= T_IDLE;
        end
        default: state <= T_IDLE;
      endcase

      if (commit) begin
        prev_x      <= cur_x;
        prev_y      <= cur_y;
        prev_z      <= cur_z;
        prev_inten  <= cur_inten;
        have_prev   <= 1'b1;
        point_index <= point_index + IDX_W'(1);
      end

      if ((state == T_FRAME) && out_free) begin
        have_prev   <= 1'b0;
        point_index <= '0;
      end
    end
  end

  // Capture of the point under work.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cur_x     <= s_tdata[COORD_W-1:0];
      cur_y     <= s_tdata[2*COORD_W-1:COORD_W];
      cur_z     <= s_tdata[3*COORD_W-1:2*COORD_W];
      cur_inten <= s_tdata[3*COORD_W+INTEN_W-1:3*COORD_W];
      cur_end   <= s_tlast;
    end
    if (state == T_CHECK) inten_ok <= inten_step <= jump_limit;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_first <= cluster_start;
      out_count <= cluster_size;
      out_acc   <= size_ok;
      out_last  <= (state == T_FRAME);
    end
  end

  assign m_tdata = {{M_PAD_W{1'b0}}, out_count, out_first};
  assign m_tuser = out_acc;
  assign m_tlast = out_last;

endmodule
